FILE: sv/circular_deque_assert.svh
// Assertion macros shared by the deque checker.
`ifndef CIRCULAR_DEQUE_ASSERT_SVH
`define CIRCULAR_DEQUE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define CDQ_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("deque check failed");

// Next-cycle implication, disabled during reset.
`define CDQ_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("deque check failed");

`endif

FILE: sv/cdq_pkg.sv
// Types and codes shared by the circular deque files.
package cdq_pkg;

   typedef logic [1:0]         kind_type;
   typedef logic [1:0]         status_type;
   typedef logic signed [31:0] word_type;

   localparam kind_type KIND_PUSH_FRONT = 2'd0;
   localparam kind_type KIND_PUSH_REAR  = 2'd1;
   localparam kind_type KIND_POP_FRONT  = 2'd2;
   localparam kind_type KIND_POP_REAR   = 2'd3;

   localparam status_type STATUS_DONE  = 2'd0;
   localparam status_type STATUS_FULL  = 2'd1;
   localparam status_type STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic take;   // latch the request transfer
      logic exec;   // perform the operation
      logic load;   // move the result into the response register
   } cdq_cmd_type;

   typedef struct packed {
      logic rsp_free;  // response register can take a result this cycle
   } cdq_stat_type;

endpackage

FILE: sv/cdq_req_if.sv
// Request channel interface of the circular deque.
interface cdq_req_if;
   import cdq_pkg::*;

   logic     valid;
   logic     ready;
   kind_type kind;
   word_type value;

   modport source (output valid, output kind, output value, input ready);
   modport sink   (input valid, input kind, input value, output ready);
endinterface

FILE: sv/cdq_rsp_if.sv
// Response channel interface of the circular deque.
interface cdq_rsp_if;
   import cdq_pkg::*;

   logic       valid;
   logic       ready;
   status_type status;
   word_type   data;
   logic       is_full;
   logic       is_empty;

   modport source (output valid, output status, output data, output is_full,
                   output is_empty, input ready);
   modport sink   (input valid, input status, input data, input is_full,
                   input is_empty, output ready);
endinterface

FILE: sv/cdq_ctrl.sv
// Sequencing state machine of the circular deque.
module cdq_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  cdq_pkg::cdq_stat_type stat,
   output cdq_pkg::cdq_cmd_type  cmd
);
   import cdq_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_EXEC = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff;
   logic [1:0] state_in;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take = 1'b1;
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            cmd.exec = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            // hold until the response register frees up
            if (stat.rsp_free) begin
               cmd.load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

FILE: sv/cdq_datapath.sv
// Pointers, ring storage and response register of the circular deque.
module cdq_datapath #(
   parameter int DEPTH = 8
) (
   input  logic                  clock,
   input  logic                  reset,
   input  cdq_pkg::cdq_cmd_type  cmd,
   output cdq_pkg::cdq_stat_type stat,
   input  cdq_pkg::kind_type     req_kind,
   input  cdq_pkg::word_type     req_value,
   cdq_rsp_if.source             rsp_ch
);
   import cdq_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam logic [AW-1:0] IDX_LAST = AW'(DEPTH - 1);

   function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
      return (i == IDX_LAST) ? '0 : i + 1'b1;
   endfunction

   function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
      return (i == '0) ? IDX_LAST : i - 1'b1;
   endfunction

   word_type ring_mem [DEPTH];

   kind_type   kind_ff;
   word_type   value_ff;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] tail_ff, tail_in;
   logic       empty_ff, empty_in;
   status_type status_ff, status_in;
   logic       pop_ok_ff, pop_ok_in;
   logic       full_ff, full_in;
   word_type   rd_data_ff;

   logic          mem_we;
   logic [AW-1:0] wr_addr;
   logic [AW-1:0] rd_addr;
   logic          full_now;
   logic          is_push;
   logic          is_front;

   logic       rsp_valid_ff, rsp_valid_in;
   status_type rsp_status_ff;
   word_type   rsp_data_ff;
   logic       rsp_full_ff;
   logic       rsp_empty_ff;

   assign is_push  = (kind_ff == KIND_PUSH_FRONT) || (kind_ff == KIND_PUSH_REAR);
   assign is_front = (kind_ff == KIND_PUSH_FRONT) || (kind_ff == KIND_POP_FRONT);
   assign full_now = !empty_ff && (idx_next(tail_ff) == head_ff);

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      empty_in  = empty_ff;
      status_in = STATUS_DONE;
      pop_ok_in = 1'b0;
      mem_we    = 1'b0;
      wr_addr   = '0;
      rd_addr   = is_front ? head_ff : tail_ff;
      if (is_push) begin
         if (full_now) begin
            status_in = STATUS_FULL;
         end else if (empty_ff) begin
            head_in  = '0;
            tail_in  = '0;
            empty_in = 1'b0;
            mem_we   = cmd.exec;
            wr_addr  = '0;
         end else if (is_front) begin
            head_in = idx_prev(head_ff);
            mem_we  = cmd.exec;
            wr_addr = head_in;
         end else begin
            tail_in = idx_next(tail_ff);
            mem_we  = cmd.exec;
            wr_addr = tail_in;
         end
      end else begin
         if (empty_ff) begin
            status_in = STATUS_EMPTY;
         end else begin
            pop_ok_in = 1'b1;
            if (head_ff == tail_ff) begin
               head_in  = '0;
               tail_in  = '0;
               empty_in = 1'b1;
            end else if (is_front) begin
               head_in = idx_next(head_ff);
            end else begin
               tail_in = idx_prev(tail_ff);
            end
         end
      end
      full_in = !empty_in && (idx_next(tail_in) == head_in);
   end

   // ring storage: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[wr_addr] <= value_ff;
      end
      if (cmd.exec) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         empty_ff <= 1'b1;
      end else if (cmd.exec) begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         empty_ff <= empty_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take) begin
         kind_ff  <= req_kind;
         value_ff <= req_value;
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         pop_ok_ff <= pop_ok_in;
         full_ff   <= full_in;
      end
   end

   assign stat.rsp_free = !rsp_valid_ff || rsp_ch.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         rsp_status_ff <= status_ff;
         rsp_data_ff   <= pop_ok_ff ? rd_data_ff : '0;
         rsp_full_ff   <= full_ff;
         rsp_empty_ff  <= empty_ff;
      end
   end

   assign rsp_ch.valid    = rsp_valid_ff;
   assign rsp_ch.status   = rsp_status_ff;
   assign rsp_ch.data     = rsp_data_ff;
   assign rsp_ch.is_full  = rsp_full_ff;
   assign rsp_ch.is_empty = rsp_empty_ff;

endmodule

FILE: sv/circular_deque.sv
// Top level of the circular deque: a double-ended queue of 32-bit words.
//
// Usage
//   req_ch carries one operation per transfer: kind selects push front,
//   push rear, pop front or pop rear; value is the word to push.
//   rsp_ch returns exactly one result per request: status (done, full,
//   empty), the popped word in data (0 otherwise), and is_full / is_empty
//   as they stand after the operation.
//   Sequencing: each request passes through the controller's take, execute
//   and load states around the ring memory's registered read; a new request
//   is taken only after the previous result has been loaded into the
//   response register.
//   Reset (synchronous, active high) empties the deque and both pointers
//   return to 0; the ring contents are not cleared.
//   When the receiver stalls, the response register holds its result and
//   the next request may still be taken and executed; it then waits in the
//   datapath until the response register frees up, and req_ch.ready stays
//   low meanwhile.
module circular_deque #(
   parameter int DEPTH = 8
) (
   input logic       clock,
   input logic       reset,
   cdq_req_if.sink   req_ch,
   cdq_rsp_if.source rsp_ch
);
   import cdq_pkg::*;

   cdq_cmd_type  cmd;
   cdq_stat_type stat;

   // sequence each request: take, execute, load result
   cdq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // hold pointers, ring words and the response register
   cdq_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_kind  (req_ch.kind),
      .req_value (req_ch.value),
      .rsp_ch    (rsp_ch)
   );

endmodule

FILE: sv/cdq_checker.sv
// Port-level checks of the circular deque and their binding.
`include "circular_deque_assert.svh"

module cdq_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input cdq_pkg::status_type rsp_status,
   input cdq_pkg::word_type   rsp_data,
   input logic               rsp_is_full,
   input logic               rsp_is_empty
);
   import cdq_pkg::*;

   // a stalled result holds
   `CDQ_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))

   // full and empty never show together
   `CDQ_ASSERT_NOW(a_full_empty, clock, reset, rsp_valid, !(rsp_is_full && rsp_is_empty))

   // a rejected push leaves the deque full
   `CDQ_ASSERT_NOW(a_full_reject, clock, reset, rsp_valid && (rsp_status == STATUS_FULL), rsp_is_full)

   // a rejected pop leaves it empty and returns no word
   `CDQ_ASSERT_NOW(a_empty_reject, clock, reset, rsp_valid && (rsp_status == STATUS_EMPTY), rsp_is_empty && (rsp_data == '0))

endmodule

bind circular_deque cdq_checker u_cdq_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_ch.valid),
   .rsp_ready    (rsp_ch.ready),
   .rsp_status   (rsp_ch.status),
   .rsp_data     (rsp_ch.data),
   .rsp_is_full  (rsp_ch.is_full),
   .rsp_is_empty (rsp_ch.is_empty)
);

FILE: sim/circular_deque_checker.sv
// Checker for the circular deque: predicts every result and compares the response channel.
`timescale 1ns / 100ps

module circular_deque_checker #(
   parameter int DEPTH = 8
) (
   input  logic clock,
   input  logic reset,
   cdq_req_if   req_mon,
   cdq_rsp_if   rsp_mon,
   output int   mismatch_count,
   output int   pending_count,
   output int   result_count,
   output int   full_reject_count,
   output int   empty_reject_count
);
   import cdq_pkg::*;

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   typedef logic [IDX_W-1:0] slot_t;

   typedef struct packed {
      status_type status;
      word_type   data;
      logic       is_full;
      logic       is_empty;
   } deque_outcome_t;

   // predicted deque contents
   word_type ring_words [DEPTH];
   slot_t    front_idx;
   slot_t    rear_idx;
   logic     deque_empty;

   deque_outcome_t expected_outcomes [$];
   deque_outcome_t want;
   deque_outcome_t got;

   initial begin
      mismatch_count     = 0;
      pending_count      = 0;
      result_count       = 0;
      full_reject_count  = 0;
      empty_reject_count = 0;
      front_idx          = '0;
      rear_idx           = '0;
      deque_empty        = 1'b1;
   end

   function automatic slot_t step_fwd(input slot_t i);
      return (i == slot_t'(DEPTH - 1)) ? '0 : slot_t'(i + 1'b1);
   endfunction

   function automatic slot_t step_back(input slot_t i);
      return (i == '0) ? slot_t'(DEPTH - 1) : slot_t'(i - 1'b1);
   endfunction

   function automatic logic ring_full();
      return !deque_empty && (step_fwd(rear_idx) == front_idx);
   endfunction

   // Apply one operation to the predicted deque and return its result.
   function automatic deque_outcome_t apply_op(input kind_type op, input word_type word);
      deque_outcome_t r;
      r.status = STATUS_DONE;
      r.data   = '0;
      if (op == KIND_PUSH_FRONT || op == KIND_PUSH_REAR) begin
         if (ring_full()) begin
            r.status = STATUS_FULL;
         end else if (deque_empty) begin
            front_idx     = '0;
            rear_idx      = '0;
            deque_empty   = 1'b0;
            ring_words[0] = word;
         end else if (op == KIND_PUSH_FRONT) begin
            front_idx             = step_back(front_idx);
            ring_words[front_idx] = word;
         end else begin
            rear_idx             = step_fwd(rear_idx);
            ring_words[rear_idx] = word;
         end
      end else begin
         if (deque_empty) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.data = (op == KIND_POP_FRONT) ? ring_words[front_idx] : ring_words[rear_idx];
            if (front_idx == rear_idx) begin
               front_idx   = '0;
               rear_idx    = '0;
               deque_empty = 1'b1;
            end else if (op == KIND_POP_FRONT) begin
               front_idx = step_fwd(front_idx);
            end else begin
               rear_idx = step_back(rear_idx);
            end
         end
      end
      r.is_full  = ring_full();
      r.is_empty = deque_empty;
      return r;
   endfunction

   task automatic check_field(input string field, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (got_v !== want_v) begin
         mismatch_count++;
         $display("%0t: %s mismatch: expected %0h, got %0h", $time, field, want_v, got_v);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         expected_outcomes.delete();
         front_idx   = '0;
         rear_idx    = '0;
         deque_empty = 1'b1;
      end else begin
         // compare before recording a new request so a stray result is never masked
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = '{status: rsp_mon.status, data: rsp_mon.data,
                    is_full: rsp_mon.is_full, is_empty: rsp_mon.is_empty};
            result_count++;
            if (expected_outcomes.size() == 0) begin
               mismatch_count++;
               $display("%0t: unexpected result: expected none, got status %0h data %0h",
                        $time, got.status, got.data);
            end else begin
               want = expected_outcomes.pop_front();
               if (want.status == STATUS_FULL)  full_reject_count++;
               if (want.status == STATUS_EMPTY) empty_reject_count++;
               check_field("status",   32'(want.status),   32'(got.status));
               check_field("data",     want.data,          got.data);
               check_field("is_full",  32'(want.is_full),  32'(got.is_full));
               check_field("is_empty", 32'(want.is_empty), 32'(got.is_empty));
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_outcomes.push_back(apply_op(req_mon.kind, req_mon.value));
      end
      pending_count = expected_outcomes.size();
   end

endmodule

FILE: sim/circular_deque_tb.sv
// Testbench top for the circular deque: stimulus, response pacing and verdict.
`timescale 1ns / 100ps

module circular_deque_tb;
   import cdq_pkg::*;

   localparam int DEPTH           = 8;
   localparam int RESET_CYCLES    = 9;
   localparam int RSP_HOLD_CYCLES = 150;   // long receiver hold-off to fill the pipeline
   localparam int SETTLE_CYCLES   = 8;     // idle time before the verdict
   localparam int WATCHDOG_LIMIT  = 2000;  // cycles without any transfer

   logic clock;
   logic reset;

   // pacing knobs, read by the sender task and the receiver process
   int send_idle_pct  = 0;
   int rsp_stall_pct  = 0;
   bit rsp_hold_req   = 1'b0;

   int sent_count     = 0;
   int quiet_cycles   = 0;

   int mismatch_count;
   int pending_count;
   int result_count;
   int full_reject_count;
   int empty_reject_count;

   cdq_req_if req_ch ();
   cdq_rsp_if rsp_ch ();

   circular_deque #(.DEPTH(DEPTH)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   circular_deque_checker #(.DEPTH(DEPTH)) deque_checker (
      .clock              (clock),
      .reset              (reset),
      .req_mon            (req_ch),
      .rsp_mon            (rsp_ch),
      .mismatch_count     (mismatch_count),
      .pending_count      (pending_count),
      .result_count       (result_count),
      .full_reject_count  (full_reject_count),
      .empty_reject_count (empty_reject_count)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Words at the edges of the signed range plus alternating bit patterns.
   function automatic word_type corner_word(input int sel);
      case (sel)
         0:       return 32'sh0000_0000;
         1:       return 32'shFFFF_FFFF;
         2:       return 32'sh7FFF_FFFF;
         3:       return 32'sh8000_0000;
         4:       return 32'sh5555_5555;
         default: return 32'shAAAA_AAAA;
      endcase
   endfunction

   // Mostly random words; now and then a corner word.
   function automatic word_type pick_word();
      if ($urandom_range(7) == 0)
         return corner_word($urandom_range(5));
      return word_type'($urandom);
   endfunction

   // Choose push or pop with the given bias, then which end at random.
   function automatic kind_type pick_kind(input int push_pct);
      bit to_front;
      to_front = 1'($urandom_range(1));
      if ($urandom_range(99) < push_pct)
         return to_front ? KIND_PUSH_FRONT : KIND_PUSH_REAR;
      return to_front ? KIND_POP_FRONT : KIND_POP_REAR;
   endfunction

   // Offer one request and hold it until the transfer happens. Leave valid
   // high afterwards; the next call either drops it for idle cycles or
   // replaces the payload, so valid never gets two updates in one step.
   task automatic send(input kind_type op, input word_type word);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.kind  <= op;
      req_ch.value <= word;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      sent_count++;
   endtask

   // Pause the sender until every predicted result has come back.
   task automatic wait_for_results();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      wait (pending_count == 0);
   endtask

   // Random traffic in bursts: fill-heavy, drain-heavy or balanced, so the
   // occupancy sweeps between empty and full over and over.
   task automatic run_traffic(input int count);
      int left;
      int burst;
      int push_pct;
      left = count;
      while (left > 0) begin
         case ($urandom_range(3))
            0:       push_pct = 85;
            1:       push_pct = 15;
            2:       push_pct = 50;
            default: push_pct = $urandom_range(100);
         endcase
         burst = $urandom_range(4, 20);
         if (burst > left) burst = left;
         repeat (burst) send(pick_kind(push_pct), pick_word());
         left -= burst;
      end
   endtask

   // Receiver: stall at the current rate, or hold off for a long stretch
   // when asked. Count the hold-off here so the sender keeps offering.
   initial begin
      forever begin
         if (rsp_hold_req) begin
            rsp_hold_req = 1'b0;
            rsp_ch.ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
            @(posedge clock);
         end
      end
   end

   // Watchdog: end the run if no transfer happens on either channel for too long.
   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("%0t: no transfer for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("** circular_deque: FAILED **");
      $finish;
   end

   initial begin
      reset        <= 1'b1;
      req_ch.valid <= 1'b0;
      req_ch.kind  <= KIND_PUSH_FRONT;
      req_ch.value <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Directed: pops on an empty deque (value is don't-care), a push onto
      // an empty deque from each end followed by popping the last word.
      send(KIND_POP_FRONT, 32'sh1234_5678);
      send(KIND_POP_REAR, 32'shFEDC_BA98);
      send(KIND_PUSH_FRONT, corner_word(3));
      send(KIND_POP_REAR, corner_word(0));
      send(KIND_PUSH_REAR, corner_word(2));
      send(KIND_POP_FRONT, corner_word(1));

      // Fill from both ends so the front pointer wraps backwards past 0.
      for (int i = 0; i < DEPTH / 2; i++) begin
         send(KIND_PUSH_FRONT, corner_word(i));
         send(KIND_PUSH_REAR, corner_word(i + 2));
      end

      // Pushes onto a full deque are rejected at either end.
      send(KIND_PUSH_FRONT, corner_word(4));
      send(KIND_PUSH_REAR, corner_word(5));

      // Drain alternately from both ends until the deque is empty.
      for (int i = 0; i < DEPTH; i++)
         send((i % 2) ? KIND_POP_REAR : KIND_POP_FRONT, pick_word());
      wait_for_results();

      // Hold off the receiver while the sender keeps going: the block
      // backs up and drops req ready.
      rsp_hold_req = 1'b1;
      run_traffic(40);
      wait_for_results();

      // Random traffic under each pacing mix.
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin send_idle_pct = 0;  rsp_stall_pct = 0;  end
            1:       begin send_idle_pct = 86; rsp_stall_pct = 0;  end
            2:       begin send_idle_pct = 0;  rsp_stall_pct = 86; end
            default: begin send_idle_pct = 37; rsp_stall_pct = 37; end
         endcase
         run_traffic((phase == 0) ? 400 : 350);
         wait_for_results();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d requests and %0d results, %0d rejected as full, %0d as empty,",
               sent_count, result_count, full_reject_count, empty_reject_count);
      $display("with free-running, sender-idle, receiver-stall and mixed pacing plus a long hold.");
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("** circular_deque: PASSED **");
      end else begin
         $display("%0d mismatches, %0d results never arrived", mismatch_count, pending_count);
         $display("** circular_deque: FAILED **");
      end
      $finish;
   end

endmodule

FILE: circular_deque.f
+incdir+sv
sv/cdq_pkg.sv
sv/cdq_req_if.sv
sv/cdq_rsp_if.sv
sv/cdq_ctrl.sv
sv/cdq_datapath.sv
sv/circular_deque.sv
sv/cdq_checker.sv
sim/circular_deque_checker.sv
sim/circular_deque_tb.sv
